// ===== rtl/brfs_pkg.sv =====
// Package for the byte ring FIFO with search: field widths, opcodes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
package brfs_pkg;

  // Fixed widths of the item fields
  localparam int OP_W   = 3;
  localparam int BYTE_W = 8;
  localparam int POFF_W = 9;
  localparam int DCNT_W = 10;
  localparam int PAT_W  = 64;
  localparam int PLEN_W = 4;
  localparam int OCC_W  = 9;

  typedef enum logic [OP_W-1:0] {
    OP_PUT     = 3'd0,
    OP_GET     = 3'd1,
    OP_PEEK    = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_DISCARD = 3'd4,
    OP_FLUSH   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SRCH_RD,
    ST_SRCH_CMP
  } state_t;

  // Kind of result the datapath commits on finish
  typedef enum logic [2:0] {
    RES_PUT,
    RES_GET,
    RES_PEEK,
    RES_FOUND,
    RES_MISS,
    RES_DISCARD,
    RES_FLUSH,
    RES_NONE
  } res_kind_t;

  typedef enum logic {
    RD_IN,
    RD_SRCH
  } rd_sel_t;

  typedef struct packed {
    logic      latch;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      adv_i;
    logic      adv_j;
    logic      finish;
    res_kind_t kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            search_ok;
    logic            match;
    logic            last_j;
    logic            i_end;
    logic            out_free;
  } dp_stat_t;

endpackage

// ===== rtl/brfs_ctrl.sv =====
// Controller state machine for the byte ring FIFO with search.
// Depends on brfs_pkg; drives ctl_cmd_t, reads dp_stat_t from brfs_dpath.
module brfs_ctrl
  import brfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd.latch  = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.rd_sel = RD_IN;
    cmd.adv_i  = 1'b0;
    cmd.adv_j  = 1'b0;
    cmd.finish = 1'b0;
    cmd.kind   = RES_NONE;
    case (state_r)
      ST_IDLE: begin
        // Take the item and start the read that get or peek needs
        if (in_valid) begin
          cmd.latch = 1'b1;
          cmd.rd_en = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (stat.op)
          OP_PUT:     cmd.kind = RES_PUT;
          OP_GET:     cmd.kind = RES_GET;
          OP_PEEK:    cmd.kind = RES_PEEK;
          OP_SEARCH:  cmd.kind = RES_MISS;
          OP_DISCARD: cmd.kind = RES_DISCARD;
          OP_FLUSH:   cmd.kind = RES_FLUSH;
          default:    cmd.kind = RES_NONE;
        endcase
        if (stat.op == OP_SEARCH && stat.search_ok) begin
          // Fetch the first candidate byte
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_SRCH;
          state_nxt  = ST_SRCH_CMP;
        end else if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_SRCH_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SRCH;
        state_nxt  = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (stat.match && stat.last_j) begin
          cmd.kind = RES_FOUND;
          if (stat.out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else if (stat.match) begin
          cmd.adv_j = 1'b1;
          state_nxt = ST_SRCH_RD;
        end else if (stat.i_end) begin
          cmd.kind = RES_MISS;
          if (stat.out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          // Restart the compare one position further on
          cmd.adv_i = 1'b1;
          state_nxt = ST_SRCH_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/brfs_dpath.sv =====
// Datapath for the byte ring FIFO with search: byte store, pointers, search
// counters and the result register. Depends on brfs_pkg; commanded by brfs_ctrl.
module brfs_dpath
  import brfs_pkg::*;
#(
  parameter int DEPTH       = 512,
  parameter int MAX_PATTERN = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [POFF_W-1:0] in_peek_offset,
  input  logic [DCNT_W-1:0] in_discard_count,
  input  logic [PAT_W-1:0]  in_pattern_bytes,
  input  logic [PLEN_W-1:0] in_pattern_length,
  input  ctl_cmd_t          cmd,
  output dp_stat_t          stat,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_success,
  output logic [BYTE_W-1:0] out_read_byte,
  output logic [POFF_W-1:0] out_match_offset,
  output logic [OCC_W-1:0]  out_occupancy
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = ((PW > DCNT_W) ? PW : DCNT_W) + 1;
  localparam int JW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int PB = BYTE_W * MAX_PATTERN;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic [PW-1:0]     rd_addr;
  logic              mem_we;

  logic [OP_W-1:0]   op_r;
  logic [BYTE_W-1:0] data_r;
  logic [POFF_W-1:0] poff_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [PB-1:0]     pat_r;
  logic [PLEN_W-1:0] plen_r;
  logic [PW-1:0]     i_r;
  logic [JW-1:0]     j_r;

  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW-1:0] avail, occ_new, drop, in_off;
  logic [CW-1:0] avail_x, dcnt_x, poff_x, in_poff_x, occ_x;
  logic          full;

  logic              out_valid_r;
  logic              ok_c;
  logic [BYTE_W-1:0] rb_c;
  logic [POFF_W-1:0] mo_c;
  logic [CW-1:0]     i_x;

  // Fill level and clamp
  assign avail     = wp_r - rp_r;
  assign avail_x   = CW'(avail);
  assign full      = (wp_r + PW'(1)) == rp_r;
  assign dcnt_x    = CW'(dcnt_r);
  assign poff_x    = CW'(poff_r);
  assign drop      = (dcnt_x > avail_x) ? avail : dcnt_x[PW-1:0];
  assign i_x       = CW'(i_r);
  assign in_poff_x = CW'(in_peek_offset);
  assign in_off    = (in_opcode == OP_PEEK) ? in_poff_x[PW-1:0] : '0;

  // Read address: the item's offset at accept, the search window otherwise
  assign rd_addr = (cmd.rd_sel == RD_SRCH) ? (rp_r + i_r + PW'(j_r)) : (rp_r + in_off);

  // Byte store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= data_r;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Hold the item's fields
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= in_opcode;
      data_r <= in_data_byte;
      poff_r <= in_peek_offset;
      dcnt_r <= in_discard_count;
      pat_r  <= in_pattern_bytes[PB-1:0];
      plen_r <= in_pattern_length;
    end
  end

  // Search position and pattern index
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.adv_i) begin
      i_r <= i_r + PW'(1);
      j_r <= '0;
    end else if (cmd.adv_j) begin
      j_r <= j_r + JW'(1);
    end
  end

  // Status to the controller
  assign stat.op        = op_r;
  assign stat.search_ok = (plen_r != '0) && (plen_r <= PLEN_W'(MAX_PATTERN))
                          && (CW'(plen_r) <= avail_x);
  assign stat.match     = rd_data_r == pat_r[BYTE_W*j_r +: BYTE_W];
  assign stat.last_j    = (PLEN_W'(j_r) + PLEN_W'(1)) == plen_r;
  assign stat.i_end     = (i_x + CW'(1) + CW'(plen_r)) > avail_x;
  assign stat.out_free  = !out_valid_r || !out_stall;

  // Commit the operation on finish
  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    mem_we = 1'b0;
    ok_c   = 1'b0;
    rb_c   = '0;
    mo_c   = '0;
    if (cmd.finish) begin
      case (cmd.kind)
        RES_PUT: begin
          if (!full) begin
            mem_we = 1'b1;
            wp_nxt = wp_r + PW'(1);
            ok_c   = 1'b1;
          end
        end
        RES_GET: begin
          if (avail != '0) begin
            rb_c   = rd_data_r;
            rp_nxt = rp_r + PW'(1);
            ok_c   = 1'b1;
          end
        end
        RES_PEEK: begin
          if (poff_x < avail_x) begin
            rb_c = rd_data_r;
            ok_c = 1'b1;
          end
        end
        RES_FOUND: begin
          ok_c = 1'b1;
          mo_c = i_x[POFF_W-1:0];
        end
        RES_DISCARD: begin
          rp_nxt = rp_r + drop;
          ok_c   = 1'b1;
        end
        RES_FLUSH: begin
          wp_nxt = '0;
          rp_nxt = '0;
          ok_c   = 1'b1;
        end
        default: begin
          ok_c = 1'b0;
        end
      endcase
    end
  end

  assign occ_new = wp_nxt - rp_nxt;
  assign occ_x   = CW'(occ_new);

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  // Result register: load on finish, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_success      <= ok_c;
      out_read_byte    <= rb_c;
      out_match_offset <= mo_c;
      out_occupancy    <= occ_x[OCC_W-1:0];
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/byte_ring_fifo_with_search_core.sv =====
// Top level of the byte ring FIFO with search.
// Depends on brfs_pkg, brfs_ctrl and brfs_dpath.
//
//  channel | ports                                      | handshake
//  --------+--------------------------------------------+-------------------
//  input   | in_opcode .. in_pattern_length             | in_valid / in_stall
//  result  | out_success .. out_occupancy               | out_valid / out_stall
//
// Put, get, peek, discard, flush and unused opcodes pass through accept
// (with the store read issued) and the execute state.
// Search runs the execute state (first byte read), then alternates compare and
// read states, one byte compare per pair; the byte store has a single read port.
// Reset (rst_n low, synchronous) empties the FIFO; the store keeps old data.
// A held result stalls completion of the next item, not its acceptance.
module byte_ring_fifo_with_search_core
  import brfs_pkg::*;
#(
  parameter int DEPTH       = 512,
  parameter int MAX_PATTERN = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic [POFF_W-1:0] in_peek_offset,
  input  logic [DCNT_W-1:0] in_discard_count,
  input  logic [PAT_W-1:0]  in_pattern_bytes,
  input  logic [PLEN_W-1:0] in_pattern_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_success,
  output logic [BYTE_W-1:0] out_read_byte,
  output logic [POFF_W-1:0] out_match_offset,
  output logic [OCC_W-1:0]  out_occupancy
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  brfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  brfs_dpath #(
    .DEPTH       (DEPTH),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_opcode         (in_opcode),
    .in_data_byte      (in_data_byte),
    .in_peek_offset    (in_peek_offset),
    .in_discard_count  (in_discard_count),
    .in_pattern_bytes  (in_pattern_bytes),
    .in_pattern_length (in_pattern_length),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_success       (out_success),
    .out_read_byte     (out_read_byte),
    .out_match_offset  (out_match_offset),
    .out_occupancy     (out_occupancy)
  );

  // An accepted item blocks the input until it completes
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting an item");

  // A held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid && out_stall))
    else $error("result committed over a stalled result");

  // A new result only follows a finish command
  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("result valid without a finished item");

  // Finish happens only while an item is in progress
  a_finish_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> in_stall)
    else $error("finish with no item in progress");

endmodule

// ===== tb/byte_ring_fifo_with_search_core_tb.sv =====
// Self-checking testbench for byte_ring_fifo_with_search_core: directed, fill/wrap
// and random traffic, with every result checked against an in-bench FIFO predictor.
// Depends on brfs_pkg and the byte_ring_fifo_with_search_core RTL.
module byte_ring_fifo_with_search_core_tb;
  import brfs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 512;
  localparam int MAX_PATTERN = 8;
  // The quiet limit covers the longest search (full FIFO, 8-byte pattern).
  localparam int QUIET_LIMIT  = 40000;
  localparam int DRAIN_CYCLES = 20;

  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic              success;
    logic [BYTE_W-1:0] read_byte;
    logic [POFF_W-1:0] match_offset;
    logic [OCC_W-1:0]  occupancy;
  } fifo_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode = '0;
  logic [BYTE_W-1:0] in_data_byte = '0;
  logic [POFF_W-1:0] in_peek_offset = '0;
  logic [DCNT_W-1:0] in_discard_count = '0;
  logic [PAT_W-1:0]  in_pattern_bytes = '0;
  logic [PLEN_W-1:0] in_pattern_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_success;
  logic [BYTE_W-1:0] out_read_byte;
  logic [POFF_W-1:0] out_match_offset;
  logic [OCC_W-1:0]  out_occupancy;

  // Predictor state: byte store and the two ring pointers
  logic [BYTE_W-1:0] fifo_mem [DEPTH];
  logic [8:0]        wr_ptr = '0;
  logic [8:0]        rd_ptr = '0;

  fifo_result_t pending_results [$];
  int           mismatches = 0;
  bit           idle_en = 1'b1;
  int           stall_left = 0;

  byte_ring_fifo_with_search_core #(
    .DEPTH      (DEPTH),
    .MAX_PATTERN(MAX_PATTERN)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_data_byte     (in_data_byte),
    .in_peek_offset   (in_peek_offset),
    .in_discard_count (in_discard_count),
    .in_pattern_bytes (in_pattern_bytes),
    .in_pattern_length(in_pattern_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_success      (out_success),
    .out_read_byte    (out_read_byte),
    .out_match_offset (out_match_offset),
    .out_occupancy    (out_occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [PAT_W-1:0] noise64();
    return {$urandom, $urandom};
  endfunction

  // Apply one operation to the predictor state and return the expected result
  function automatic fifo_result_t predict_fifo_op(
    input logic [OP_W-1:0]   op,
    input logic [BYTE_W-1:0] data,
    input logic [POFF_W-1:0] poff,
    input logic [DCNT_W-1:0] dcnt,
    input logic [PAT_W-1:0]  pat,
    input logic [PLEN_W-1:0] plen
  );
    fifo_result_t r;
    logic [8:0]   avail;
    logic [8:0]   nxt;
    logic [8:0]   idx;
    logic [8:0]   drop;
    logic         hit;
    r = '0;
    avail = wr_ptr - rd_ptr;
    case (op)
      OP_PUT: begin
        nxt = wr_ptr + 9'd1;
        if (nxt != rd_ptr) begin
          fifo_mem[wr_ptr] = data;
          wr_ptr = nxt;
          r.success = 1'b1;
        end
      end
      OP_GET: begin
        if (avail != 0) begin
          r.read_byte = fifo_mem[rd_ptr];
          rd_ptr = rd_ptr + 9'd1;
          r.success = 1'b1;
        end
      end
      OP_PEEK: begin
        if (poff < avail) begin
          idx = rd_ptr + poff;
          r.read_byte = fifo_mem[idx];
          r.success = 1'b1;
        end
      end
      OP_SEARCH: begin
        // Naive scan: first offset where all pattern bytes line up
        if (plen != 0 && plen <= MAX_PATTERN && plen <= avail) begin
          for (int i = 0; i + plen <= avail && !r.success; i++) begin
            hit = 1'b1;
            for (int j = 0; j < plen; j++) begin
              idx = 9'(rd_ptr + i + j);
              if (fifo_mem[idx] != pat[8*j +: 8]) hit = 1'b0;
            end
            if (hit) begin
              r.success = 1'b1;
              r.match_offset = 9'(i);
            end
          end
        end
      end
      OP_DISCARD: begin
        drop = (dcnt > avail) ? avail : dcnt[8:0];
        rd_ptr = rd_ptr + drop;
        r.success = 1'b1;
      end
      OP_FLUSH: begin
        wr_ptr = '0;
        rd_ptr = '0;
        r.success = 1'b1;
      end
      default: ;
    endcase
    r.occupancy = wr_ptr - rd_ptr;
    return r;
  endfunction

  // Build a pattern from the unread bytes at off; bytes past len stay random
  function automatic logic [PAT_W-1:0] pattern_from_fifo(int unsigned off, int unsigned len);
    logic [PAT_W-1:0] p;
    logic [8:0]       idx;
    p = noise64();
    for (int j = 0; j < len; j++) begin
      idx = 9'(rd_ptr + off + j);
      p[8*j +: 8] = fifo_mem[idx];
    end
    return p;
  endfunction

  // Drive one item, hold it until accepted, then queue its expected result
  task automatic send_item(
    input logic [OP_W-1:0]  op,
    input int unsigned      data,
    input int unsigned      poff,
    input int unsigned      dcnt,
    input logic [PAT_W-1:0] pat,
    input int unsigned      plen
  );
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_data_byte      <= BYTE_W'(data);
    in_peek_offset    <= POFF_W'(poff);
    in_discard_count  <= DCNT_W'(dcnt);
    in_pattern_bytes  <= pat;
    in_pattern_length <= PLEN_W'(plen);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_fifo_op(op, BYTE_W'(data), POFF_W'(poff),
                                              DCNT_W'(dcnt), pat, PLEN_W'(plen)));
  endtask

  // Drop valid and hold off until every queued result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic flag_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Empty-FIFO corners, every opcode, peek and search edge cases, clamped discard
  task automatic test_directed_ops();
    send_item(OP_GET, $urandom, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_PEEK, $urandom, 0, $urandom, noise64(), $urandom);
    send_item(OP_SEARCH, $urandom, $urandom, $urandom, noise64(), 1);
    send_item(OP_DISCARD, $urandom, $urandom, 512, noise64(), $urandom);
    send_item(OP_RSVD_6, $urandom, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_RSVD_7, $urandom, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_PUT, 'h00, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_PUT, 'hFF, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_PUT, 'h5A, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_PUT, 'hA5, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_PUT, 'hFF, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_PEEK, $urandom, 0, $urandom, noise64(), $urandom);
    send_item(OP_PEEK, $urandom, 4, $urandom, noise64(), $urandom);
    send_item(OP_PEEK, $urandom, 5, $urandom, noise64(), $urandom);
    send_item(OP_PEEK, $urandom, 511, $urandom, noise64(), $urandom);
    send_item(OP_SEARCH, $urandom, $urandom, $urandom, noise64(), 0);
    send_item(OP_SEARCH, $urandom, $urandom, $urandom, noise64(), 9);
    send_item(OP_SEARCH, $urandom, $urandom, $urandom, '1, 15);
    send_item(OP_SEARCH, $urandom, $urandom, $urandom, pattern_from_fifo(0, 5), 6);
    send_item(OP_SEARCH, $urandom, $urandom, $urandom, pattern_from_fifo(3, 2), 2);
    send_item(OP_SEARCH, $urandom, $urandom, $urandom, 64'h0000_0000_0000_FFFF, 2);
    send_item(OP_SEARCH, $urandom, $urandom, $urandom, pattern_from_fifo(0, 5), 5);
    send_item(OP_GET, $urandom, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_DISCARD, $urandom, $urandom, 0, noise64(), $urandom);
    send_item(OP_DISCARD, $urandom, $urandom, 1023, noise64(), $urandom);
    send_item(OP_FLUSH, $urandom, $urandom, $urandom, noise64(), $urandom);
  endtask

  // Fill to DEPTH-1, overflow, search at full occupancy, then wrap the pointers
  task automatic test_fill_and_wrap();
    send_item(OP_FLUSH, $urandom, $urandom, $urandom, noise64(), $urandom);
    repeat (DEPTH) send_item(OP_PUT, $urandom, $urandom, $urandom, noise64(), $urandom);
    wait_drained();
    send_item(OP_PUT, $urandom, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_PEEK, $urandom, 510, $urandom, noise64(), $urandom);
    send_item(OP_PEEK, $urandom, 511, $urandom, noise64(), $urandom);
    send_item(OP_SEARCH, $urandom, $urandom, $urandom, pattern_from_fifo(503, 8), 8);
    send_item(OP_SEARCH, $urandom, $urandom, $urandom, noise64(), 8);
    send_item(OP_GET, $urandom, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_DISCARD, $urandom, $urandom, 1023, noise64(), $urandom);
    repeat (20) send_item(OP_PUT, $urandom, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_SEARCH, $urandom, $urandom, $urandom, pattern_from_fifo(0, 8), 8);
    send_item(OP_PEEK, $urandom, 19, $urandom, noise64(), $urandom);
    send_item(OP_GET, $urandom, $urandom, $urandom, noise64(), $urandom);
    send_item(OP_DISCARD, $urandom, $urandom, 7, noise64(), $urandom);
    send_item(OP_FLUSH, $urandom, $urandom, $urandom, noise64(), $urandom);
  endtask

  // Mixed traffic; searches mostly use patterns lifted from the FIFO contents
  task automatic test_random_traffic(input int unsigned n_items);
    logic [8:0]       occ;
    int unsigned      pick;
    int unsigned      cap;
    int unsigned      len;
    int unsigned      off;
    int unsigned      bpos;
    logic [PAT_W-1:0] pat;
    int unsigned      data;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k == n_items - n_items / 4) idle_en = 1'b0;
      occ = wr_ptr - rd_ptr;
      pick = $urandom_range(0, 99);
      // Keep occupancy moderate so searches stay short
      if (pick < 38 && occ > 9'd250) pick = 45;
      if (pick < 38 || pick >= 97) begin
        data = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 255);
        send_item(OP_PUT, data, $urandom, $urandom, noise64(), $urandom);
      end else if (pick < 55) begin
        send_item(OP_GET, $urandom, $urandom, $urandom, noise64(), $urandom);
      end else if (pick < 66) begin
        off = (occ != 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, occ - 1) : $urandom;
        send_item(OP_PEEK, $urandom, off, $urandom, noise64(), $urandom);
      end else if (pick < 82) begin
        if (occ != 0 && $urandom_range(0, 3) != 0) begin
          cap = (occ < MAX_PATTERN) ? occ : MAX_PATTERN;
          len = $urandom_range(1, cap);
          off = $urandom_range(0, occ - len);
          pat = pattern_from_fifo(off, len);
          if ($urandom_range(0, 3) == 0) begin
            bpos = $urandom_range(0, len - 1);
            pat[8*bpos +: 8] = 8'($urandom);
          end
          send_item(OP_SEARCH, $urandom, $urandom, $urandom, pat, len);
        end else begin
          send_item(OP_SEARCH, $urandom, $urandom, $urandom, noise64(), $urandom_range(0, 15));
        end
      end else if (pick < 90) begin
        send_item(OP_DISCARD, $urandom, $urandom,
                  $urandom_range(0, 3) != 0 ? $urandom_range(0, 8) : $urandom_range(0, 1023),
                  noise64(), $urandom);
      end else if (pick < 94) begin
        send_item(OP_FLUSH, $urandom, $urandom, $urandom, noise64(), $urandom);
      end else begin
        send_item($urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7, $urandom, $urandom, $urandom,
                  noise64(), $urandom);
      end
    end
  endtask

  // Check each accepted result against the oldest expectation; drive stall bursts
  always @(posedge clk) begin : result_check
    fifo_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got occupancy %0d", $time,
                 out_occupancy);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        flag_field("success", 9'(want.success), 9'(out_success));
        flag_field("read_byte", 9'(want.read_byte), 9'(out_read_byte));
        flag_field("match_offset", want.match_offset, out_match_offset);
        flag_field("occupancy", want.occupancy, out_occupancy);
      end
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // End the run when no item moves on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("byte_ring_fifo_with_search_core_tb failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_fill_and_wrap();
    test_random_traffic(80);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("byte_ring_fifo_with_search_core_tb passed");
    end else begin
      $display("byte_ring_fifo_with_search_core_tb failed");
    end
    $finish;
  end

endmodule
